// ----- rtl/core/mkwf_pkg.sv -----
package mkwf_pkg;

    // fixed field and datapath widths
    localparam int CNT_W    = 12;
    localparam int SA_W     = 13;
    localparam int PIX_W    = 10;
    localparam int DIST_W   = 10;
    localparam int ACC_W    = 20;
    localparam int SQ_STEPS = 10;
    localparam int K_W      = 10;
    localparam int SUM_W    = 18;
    localparam int NB_W     = 4;
    localparam int RAD_W    = 4;

    localparam logic [CNT_W-1:0] CNT_MAX = 12'hFFF;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_BAD_K = 2'd1;
    localparam logic [1:0] STATUS_COUNT = 2'd2;

    localparam logic [1:0] CFG_RADIUS     = 2'd0;
    localparam logic [1:0] CFG_NEIGHBOURS = 2'd1;
    localparam logic [1:0] CFG_BANDS      = 2'd2;

    typedef struct packed {
        logic [7:0] sample;
        logic       last;
    } item_t;

    typedef struct packed {
        logic [7:0] band_value;
        logic [2:0] band_index;
        logic [1:0] status;
        logic       last_band;
    } result_t;

    typedef struct packed {
        logic             valid;
        logic [PIX_W-1:0] pix;
        logic [ACC_W-1:0] rem;
        logic [ACC_W-1:0] root;
    } sq_stage_t;

    typedef enum logic [3:0] {
        S_LOAD,
        S_CENTRE,
        S_DIST,
        S_SEL,
        S_SUM_RD,
        S_SUM_CHK,
        S_SUM_BAND,
        S_SUM_END,
        S_DIV_LD,
        S_DIV,
        S_ERR
    } state_t;

endpackage

// ----- rtl/core/mkwf_ram.sv -----
module mkwf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/mkwf_sqrt_cell.sv -----
module mkwf_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mkwf_pkg::sq_stage_t   din,
    output mkwf_pkg::sq_stage_t   dout
);

    import mkwf_pkg::*;

    localparam logic [ACC_W-1:0] BITV = ACC_W'(1) << (2 * (SQ_STEPS - 1 - STEP));

    sq_stage_t      dout_reg;
    sq_stage_t      dout_next;
    logic [ACC_W:0] trial;

    // one result bit per cell
    always_comb
    begin
        trial     = {1'b0, din.root} + {1'b0, BITV};
        dout_next = din;
        if ({1'b0, din.rem} >= trial)
        begin
            dout_next.rem  = din.rem - trial[ACC_W-1:0];
            dout_next.root = (din.root >> 1) + BITV;
        end
        else
        begin
            dout_next.root = din.root >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dout_reg <= '0;
        end
        else
        begin
            dout_reg <= dout_next;
        end
    end

    assign dout = dout_reg;

endmodule

// ----- rtl/core/multiband_knn_window_filter_unit.sv -----
// flow: a window of N samples loads at one sample per cycle while start is held and the block
// is idle, then the block is busy for the centre read, the distances, the threshold search,
// the sums, and the divide and output; an error window outputs nb results; each result shows
// in the cycle after its computing cycle.
// throughput: one window at a time, set by the single read port of the sample store and the
// ten passes over the distance store. results are strobed once per band and the receiver cannot
// stall. async reset clears control, counter and config.
module multiband_knn_window_filter_unit #(
    parameter int MAX_RADIUS = 15,
    parameter int BANDS      = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  mkwf_pkg::item_t   in_item,
    output logic              result_strobe,
    output mkwf_pkg::result_t result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [9:0]        cfg_data
);

    import mkwf_pkg::*;

    localparam int SIDE_MAX    = 2 * MAX_RADIUS + 1;
    localparam int PIX_MAX     = SIDE_MAX * SIDE_MAX;
    localparam int STORE_DEPTH = PIX_MAX * BANDS;
    localparam int SAW         = $clog2(STORE_DEPTH);
    localparam int PAW         = $clog2(PIX_MAX);
    localparam int BW          = (BANDS > 1) ? $clog2(BANDS) : 1;

    // configuration registers
    logic [RAD_W-1:0] cfg_radius_reg, cfg_radius_next;
    logic [K_W-1:0]   cfg_k_reg, cfg_k_next;
    logic [NB_W-1:0]  cfg_nb_reg, cfg_nb_next;

    // control
    state_t           state_reg, state_next;
    logic [CNT_W-1:0] counter_reg, counter_next;
    logic [SA_W-1:0]  da_reg, da_next;
    logic [NB_W-1:0]  db_reg, db_next;
    logic [PIX_W-1:0] dp_reg, dp_next;
    logic             act_reg, act_next;
    logic             cap_reg, cap_next;
    logic [NB_W-1:0]  capb_reg, capb_next;

    // distance pipeline ahead of the root chain
    logic             v1_reg, v1_next;
    logic [NB_W-1:0]  b1_reg, b1_next;
    logic             first1_reg, first1_next;
    logic             last1_reg, last1_next;
    logic [PIX_W-1:0] pix1_reg, pix1_next;
    logic             v2_reg, v2_next;
    logic             first2_reg, first2_next;
    logic             last2_reg, last2_next;
    logic [PIX_W-1:0] pix2_reg, pix2_next;
    logic [15:0]      sq_reg, sq_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    sq_stage_t        chain_in_reg, chain_in_next;

    // threshold search
    logic [3:0]        sb_reg, sb_next;
    logic [DIST_W-1:0] xv_reg, xv_next;
    logic [K_W-1:0]    keep_reg, keep_next;
    logic [K_W-1:0]    cnt_reg, cnt_next;
    logic [PIX_W-1:0]  sp_reg, sp_next;
    logic              rv_reg, rv_next;
    logic [PIX_W-1:0]  rp_reg, rp_next;

    // sums and divide
    logic [SA_W-1:0]  pbase_reg, pbase_next;
    logic [K_W-1:0]   taken_reg, taken_next;
    logic [7:0]       centre_reg [BANDS];
    logic [7:0]       centre_next [BANDS];
    logic [SUM_W-1:0] sums_reg [BANDS];
    logic [SUM_W-1:0] sums_next [BANDS];
    logic [SUM_W-1:0] rem_reg, rem_next;
    logic [7:0]       q_reg, q_next;
    logic [2:0]       qi_reg, qi_next;
    logic [NB_W-1:0]  ob_reg, ob_next;
    logic [1:0]       st_reg, st_next;
    result_t          result_reg, result_next;
    logic             strobe_reg, strobe_next;

    // derived window geometry, from the config registers (stable while busy)
    logic [RAD_W-1:0]  r_eff;
    logic [NB_W-1:0]   nb_eff;
    logic [4:0]        side;
    logic [PIX_W-1:0]  npix;
    logic [PIX_W-1:0]  npix_m1;
    logic [PIX_W-1:0]  cpix;
    logic [13:0]       expected;
    logic [SA_W-1:0]   cbase;
    logic [CNT_W-1:0]  cnt_inc;
    logic [1:0]        win_status;
    logic              accept;

    // memories
    logic              s_we;
    logic [SA_W-1:0]   s_raddr;
    logic [7:0]        s_rdata;
    logic [DIST_W-1:0] d_rdata;
    sq_stage_t         sq_chain [SQ_STEPS+1];

    // datapath temporaries
    logic [7:0]        cval;
    logic [7:0]        diff;
    logic [ACC_W-1:0]  acc_sum;
    logic [DIST_W-1:0] try_val;
    logic [K_W-1:0]    sel_total;
    logic [K_W-1:0]    m_need;
    logic              incl;
    logic              tie_take;
    logic [10:0]       dk;
    logic [SUM_W-1:0]  trial;
    logic              q_bit;

    assign r_eff   = (cfg_radius_reg > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : cfg_radius_reg;
    assign nb_eff  = (cfg_nb_reg == '0) ? NB_W'(1) :
                     ((cfg_nb_reg > NB_W'(BANDS)) ? NB_W'(BANDS) : cfg_nb_reg);
    assign side     = {r_eff, 1'b1};
    assign npix     = PIX_W'({5'b0, side} * {5'b0, side});
    assign npix_m1  = npix - PIX_W'(1);
    assign cpix     = npix_m1 >> 1;
    assign expected = {4'b0, npix} * {10'b0, nb_eff};
    assign cbase    = SA_W'({3'b0, cpix} * {9'b0, nb_eff});
    assign cnt_inc  = (counter_reg == CNT_MAX) ? counter_reg : counter_reg + CNT_W'(1);
    assign dk       = {1'b0, cfg_k_reg} + 11'd1;
    assign m_need   = cfg_k_reg - keep_reg;

    assign accept    = start && (state_reg == S_LOAD);
    assign busy      = (state_reg != S_LOAD);
    // config only moves while no window is being processed
    assign cfg_ready = (state_reg == S_LOAD);

    // status checked at the final sample: bad k first, then the sample count
    always_comb
    begin
        if ((cfg_k_reg == '0) || (cfg_k_reg > npix_m1))
        begin
            win_status = STATUS_BAD_K;
        end
        else if ({2'b0, cnt_inc} != expected)
        begin
            win_status = STATUS_COUNT;
        end
        else
        begin
            win_status = STATUS_OK;
        end
    end

    // sample store: written while loading, read by centre, distance and sum passes
    assign s_we = accept && (SA_W'(counter_reg) < SA_W'(STORE_DEPTH));

    mkwf_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_samples (
        .clk   (clk),
        .we    (s_we),
        .waddr (SAW'(counter_reg)),
        .wdata (in_item.sample),
        .raddr (s_raddr[SAW-1:0]),
        .rdata (s_rdata)
    );

    // distance store: written from the end of the root chain, read by pixel index
    mkwf_ram #(
        .WIDTH (DIST_W),
        .DEPTH (PIX_MAX)
    ) u_dist (
        .clk   (clk),
        .we    (sq_chain[SQ_STEPS].valid),
        .waddr (sq_chain[SQ_STEPS].pix[PAW-1:0]),
        .wdata (sq_chain[SQ_STEPS].root[DIST_W-1:0]),
        .raddr (sp_reg[PAW-1:0]),
        .rdata (d_rdata)
    );

    // integer square root as a chain of cells, one root bit per cell
    assign sq_chain[0] = chain_in_reg;

    for (genvar gi = 0; gi < SQ_STEPS; gi++)
    begin : g_sqrt
        mkwf_sqrt_cell #(
            .STEP (gi)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .din   (sq_chain[gi]),
            .dout  (sq_chain[gi+1])
        );
    end

    always_comb
    begin
        unique case (state_reg)
            S_CENTRE:   s_raddr = cbase + SA_W'(db_reg);
            S_SUM_BAND: s_raddr = pbase_reg + SA_W'(db_reg);
            default:    s_raddr = da_reg;
        endcase
    end

    // next state and datapath
    always_comb
    begin
        cfg_radius_next = cfg_radius_reg;
        cfg_k_next      = cfg_k_reg;
        cfg_nb_next     = cfg_nb_reg;
        state_next      = state_reg;
        counter_next    = counter_reg;
        da_next         = da_reg;
        db_next         = db_reg;
        dp_next         = dp_reg;
        act_next        = act_reg;
        cap_next        = 1'b0;
        capb_next       = capb_reg;
        sb_next         = sb_reg;
        xv_next         = xv_reg;
        keep_next       = keep_reg;
        cnt_next        = cnt_reg;
        sp_next         = sp_reg;
        rv_next         = 1'b0;
        rp_next         = sp_reg;
        pbase_next      = pbase_reg;
        taken_next      = taken_reg;
        centre_next     = centre_reg;
        sums_next       = sums_reg;
        rem_next        = rem_reg;
        q_next          = q_reg;
        qi_next         = qi_reg;
        ob_next         = ob_reg;
        st_next         = st_reg;
        result_next     = result_reg;
        strobe_next     = 1'b0;
        incl            = 1'b0;
        tie_take        = 1'b0;
        sel_total       = '0;
        trial           = '0;
        q_bit           = 1'b0;

        // config writes
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_RADIUS:     cfg_radius_next = cfg_data[RAD_W-1:0];
                CFG_NEIGHBOURS: cfg_k_next      = cfg_data[K_W-1:0];
                CFG_BANDS:      cfg_nb_next     = cfg_data[NB_W-1:0];
                default:        ;
            endcase
        end

        // distance front end: |sample - centre| squared, summed over bands
        cval    = centre_reg[b1_reg[BW-1:0]];
        diff    = (s_rdata > cval) ? (s_rdata - cval) : (cval - s_rdata);
        sq_next = {8'b0, diff} * {8'b0, diff};
        v1_next     = 1'b0;
        b1_next     = db_reg;
        first1_next = (db_reg == '0);
        last1_next  = (db_reg == nb_eff - NB_W'(1));
        pix1_next   = dp_reg;
        v2_next     = v1_reg;
        first2_next = first1_reg;
        last2_next  = last1_reg;
        pix2_next   = pix1_reg;
        acc_sum     = (first2_reg ? '0 : acc_reg) + ACC_W'(sq_reg);
        acc_next    = v2_reg ? acc_sum : acc_reg;
        chain_in_next.valid = v2_reg && last2_reg;
        chain_in_next.pix   = pix2_reg;
        chain_in_next.rem   = acc_sum;
        chain_in_next.root  = '0;

        // captures land in the cycle after their read transfer
        if (cap_reg)
        begin
            if (state_reg == S_CENTRE)
            begin
                centre_next[capb_reg[BW-1:0]] = s_rdata;
            end
            else
            begin
                sums_next[capb_reg[BW-1:0]] = sums_reg[capb_reg[BW-1:0]] + SUM_W'(s_rdata);
            end
        end

        try_val = xv_reg | (DIST_W'(1) << sb_reg);

        unique case (state_reg)
            S_LOAD:
            begin
                if (accept)
                begin
                    counter_next = cnt_inc;
                    if (in_item.last)
                    begin
                        counter_next = '0;
                        st_next      = win_status;
                        ob_next      = '0;
                        db_next      = '0;
                        act_next     = 1'b1;
                        if (win_status == STATUS_OK)
                        begin
                            state_next = S_CENTRE;
                        end
                        else
                        begin
                            state_next = S_ERR;
                        end
                    end
                end
            end

            // read the centre pixel bands
            S_CENTRE:
            begin
                if (act_reg)
                begin
                    cap_next  = 1'b1;
                    capb_next = db_reg;
                    if (db_reg == nb_eff - NB_W'(1))
                    begin
                        act_next = 1'b0;
                    end
                    else
                    begin
                        db_next = db_reg + NB_W'(1);
                    end
                end
                else if (!cap_reg)
                begin
                    state_next = S_DIST;
                    da_next    = '0;
                    db_next    = '0;
                    dp_next    = '0;
                    act_next   = 1'b1;
                end
            end

            // stream every sample through the distance pipe and root chain
            S_DIST:
            begin
                if (act_reg)
                begin
                    v1_next = 1'b1;
                    da_next = da_reg + SA_W'(1);
                    if (db_reg == nb_eff - NB_W'(1))
                    begin
                        db_next = '0;
                        if (dp_reg == npix_m1)
                        begin
                            act_next = 1'b0;
                        end
                        else
                        begin
                            dp_next = dp_reg + PIX_W'(1);
                        end
                    end
                    else
                    begin
                        db_next = db_reg + NB_W'(1);
                    end
                end
                if (sq_chain[SQ_STEPS].valid && (sq_chain[SQ_STEPS].pix == npix_m1))
                begin
                    state_next = S_SEL;
                    sb_next    = 4'(DIST_W - 1);
                    xv_next    = '0;
                    keep_next  = '0;
                    cnt_next   = '0;
                    sp_next    = '0;
                    act_next   = 1'b1;
                end
            end

            // bitwise search for the k-th smallest distance, one pass per bit
            S_SEL:
            begin
                if (act_reg)
                begin
                    rv_next = 1'b1;
                    if (sp_reg == npix_m1)
                    begin
                        act_next = 1'b0;
                    end
                    else
                    begin
                        sp_next = sp_reg + PIX_W'(1);
                    end
                end
                if (rv_reg)
                begin
                    sel_total = cnt_reg;
                    if ((rp_reg != cpix) && (d_rdata < try_val))
                    begin
                        sel_total = cnt_reg + K_W'(1);
                    end
                    cnt_next = sel_total;
                    if (rp_reg == npix_m1)
                    begin
                        cnt_next = '0;
                        if (sel_total < cfg_k_reg)
                        begin
                            xv_next   = try_val;
                            keep_next = sel_total;
                        end
                        sp_next  = '0;
                        act_next = 1'b1;
                        if (sb_reg == '0)
                        begin
                            state_next = S_SUM_RD;
                            act_next   = 1'b0;
                            pbase_next = '0;
                            taken_next = '0;
                            for (int i = 0; i < BANDS; i++)
                            begin
                                sums_next[i] = '0;
                            end
                        end
                        else
                        begin
                            sb_next = sb_reg - 4'd1;
                        end
                    end
                end
            end

            S_SUM_RD:
            begin
                state_next = S_SUM_CHK;
            end

            // centre, all below threshold, and the first ties in index order
            S_SUM_CHK:
            begin
                tie_take = (sp_reg != cpix) && (d_rdata == xv_reg) && (taken_reg < m_need);
                incl     = (sp_reg == cpix) || (d_rdata < xv_reg) || tie_take;
                if (tie_take)
                begin
                    taken_next = taken_reg + K_W'(1);
                end
                if (incl)
                begin
                    state_next = S_SUM_BAND;
                    db_next    = '0;
                end
                else if (sp_reg == npix_m1)
                begin
                    state_next = S_SUM_END;
                end
                else
                begin
                    sp_next    = sp_reg + PIX_W'(1);
                    pbase_next = pbase_reg + SA_W'(nb_eff);
                    state_next = S_SUM_RD;
                end
            end

            S_SUM_BAND:
            begin
                cap_next  = 1'b1;
                capb_next = db_reg;
                if (db_reg == nb_eff - NB_W'(1))
                begin
                    if (sp_reg == npix_m1)
                    begin
                        state_next = S_SUM_END;
                    end
                    else
                    begin
                        sp_next    = sp_reg + PIX_W'(1);
                        pbase_next = pbase_reg + SA_W'(nb_eff);
                        state_next = S_SUM_RD;
                    end
                end
                else
                begin
                    db_next = db_reg + NB_W'(1);
                end
            end

            S_SUM_END:
            begin
                ob_next    = '0;
                state_next = S_DIV_LD;
            end

            S_DIV_LD:
            begin
                rem_next   = sums_reg[0];
                q_next     = '0;
                qi_next    = 3'd7;
                state_next = S_DIV;
            end

            // restoring divide by k+1, one quotient bit per cycle
            S_DIV:
            begin
                trial = SUM_W'(dk) << qi_reg;
                if (rem_reg >= trial)
                begin
                    rem_next = rem_reg - trial;
                    q_bit    = 1'b1;
                end
                q_next = q_reg | (8'(q_bit) << qi_reg);
                if (qi_reg == '0)
                begin
                    strobe_next            = 1'b1;
                    result_next.band_value = q_next;
                    result_next.band_index = ob_reg[2:0];
                    result_next.status     = STATUS_OK;
                    result_next.last_band  = (ob_reg == nb_eff - NB_W'(1));
                    for (int i = 0; i < BANDS - 1; i++)
                    begin
                        sums_next[i] = sums_reg[i+1];
                    end
                    sums_next[BANDS-1] = '0;
                    ob_next            = ob_reg + NB_W'(1);
                    if (ob_reg == nb_eff - NB_W'(1))
                    begin
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        state_next = S_DIV_LD;
                    end
                end
                else
                begin
                    qi_next = qi_reg - 3'd1;
                end
            end

            S_ERR:
            begin
                strobe_next            = 1'b1;
                result_next.band_value = '0;
                result_next.band_index = ob_reg[2:0];
                result_next.status     = st_reg;
                result_next.last_band  = (ob_reg == nb_eff - NB_W'(1));
                ob_next                = ob_reg + NB_W'(1);
                if (ob_reg == nb_eff - NB_W'(1))
                begin
                    state_next = S_LOAD;
                end
            end

            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_radius_reg <= RAD_W'(1);
            cfg_k_reg      <= K_W'(1);
            cfg_nb_reg     <= NB_W'(1);
            state_reg      <= S_LOAD;
            counter_reg    <= '0;
            act_reg        <= 1'b0;
            cap_reg        <= 1'b0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            chain_in_reg   <= '0;
            rv_reg         <= 1'b0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            cfg_radius_reg <= cfg_radius_next;
            cfg_k_reg      <= cfg_k_next;
            cfg_nb_reg     <= cfg_nb_next;
            state_reg      <= state_next;
            counter_reg    <= counter_next;
            act_reg        <= act_next;
            cap_reg        <= cap_next;
            v1_reg         <= v1_next;
            v2_reg         <= v2_next;
            chain_in_reg   <= chain_in_next;
            rv_reg         <= rv_next;
            strobe_reg     <= strobe_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        da_reg      <= da_next;
        db_reg      <= db_next;
        dp_reg      <= dp_next;
        capb_reg    <= capb_next;
        b1_reg      <= b1_next;
        first1_reg  <= first1_next;
        last1_reg   <= last1_next;
        pix1_reg    <= pix1_next;
        first2_reg  <= first2_next;
        last2_reg   <= last2_next;
        pix2_reg    <= pix2_next;
        sq_reg      <= sq_next;
        acc_reg     <= acc_next;
        sb_reg      <= sb_next;
        xv_reg      <= xv_next;
        keep_reg    <= keep_next;
        cnt_reg     <= cnt_next;
        sp_reg      <= sp_next;
        rp_reg      <= rp_next;
        pbase_reg   <= pbase_next;
        taken_reg   <= taken_next;
        centre_reg  <= centre_next;
        sums_reg    <= sums_next;
        rem_reg     <= rem_next;
        q_reg       <= q_next;
        qi_reg      <= qi_next;
        ob_reg      <= ob_next;
        st_reg      <= st_next;
        result_reg  <= result_next;
    end

    assign result_strobe = strobe_reg;
    assign result        = result_reg;

    // the block only goes idle together with the final result of a window
    a_idle_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !busy) |-> result.last_band)
        else $error("result outside busy that is not the final band");

    // an error window always reports zero
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && (result.status != STATUS_OK)) |-> (result.band_value == 8'd0))
        else $error("error result with nonzero value");

    // the final sample transfer starts window processing
    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && in_item.last) |=> busy)
        else $error("no processing after final sample");

endmodule
